>>> sv/bounded_deque_with_key_insert_core_macros.svh
// Assertion macros used by the deque top level.
`ifndef BOUNDED_DEQUE_WITH_KEY_INSERT_CORE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_KEY_INSERT_CORE_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define DQK_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define DQK_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/dqk_pkg.sv
// Shared types and constants of the bounded deque with keyed insert.
package dqk_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FUNC_W         = 3;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_BACK     = 3'd0,
      FN_PUSH_FRONT    = 3'd1,
      FN_POP_FRONT     = 3'd2,
      FN_POP_BACK      = 3'd3,
      FN_SEARCH        = 3'd4,
      FN_INSERT_AFTER  = 3'd5,
      FN_INSERT_BEFORE = 3'd6,
      FN_CLEAR         = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      SC_OK    = 2'd0,
      SC_EMPTY = 2'd1,
      SC_FULL  = 2'd2,
      SC_NOKEY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic     init;
      logic     scan;
      logic     apply;
      func_type func;
   } cell_ctl_type;

endpackage

>>> sv/bounded_deque_with_key_insert_core.sv
// Top level of the bounded deque with keyed insert, built as a row of slot cells.
//
//   channel | dir | tdata (low bit up)                       | tuser
//   req     | in  | value, key, zero pad                     | func
//   rsp     | out | data, found, status, fill_count, zero pad| -
//
// Push back, push front, pop front and clear: the request is taken in idle, and
// the apply state then loads the result into the output register.
// Pop back, search and the inserts pass through the scan state between idle and
// apply; its steps are the doubling steps of the match prefix and data carrier
// across the cells. The next request is taken only once the block is back in idle.
// Reset zeroes the fill count, state, scan step and output valid; slot contents
// stay unknown until written. req_tready is high only while idle; a result still
// held in the output register stalls the block in apply, and no request is taken then.
module bounded_deque_with_key_insert_core
   import dqk_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int CW   = $clog2(DEPTH + 1),
   localparam int RQ_W = ((2 * DATA_WIDTH + 7) / 8) * 8,
   localparam int RS_RAW = DATA_WIDTH + 3 + CW,
   localparam int RS_W = ((RS_RAW + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [RQ_W-1:0]   req_tdata,   // value, key
   input  logic [FUNC_W-1:0] req_tuser,   // func
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RS_W-1:0]   rsp_tdata    // data, found, status, fill_count
);

   `include "bounded_deque_with_key_insert_core_macros.svh"

   localparam int DW  = DATA_WIDTH;
   localparam int LOG = $clog2(DEPTH);
   localparam int SW  = (LOG > 1) ? $clog2(LOG) : 1;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [SW-1:0]   step_ff, step_in;
   func_type        func_ff, func_in;
   logic [DW-1:0]   value_ff, value_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RS_W-1:0] rsp_data_ff, rsp_data_in;

   cell_ctl_type    ctl;
   logic [DW-1:0]   cell_value;
   logic [DW-1:0]   req_value, req_key;
   func_type        req_func;
   logic            accept, slot_free, needs_scan;

   // result of the operation in flight, valid in the apply cycle
   logic [DW-1:0]   res_data;
   logic            res_found;
   status_type      res_status;
   logic [CW-1:0]   res_count;
   logic            res_commit;

   logic [DW-1:0]   elem_w [DEPTH];
   logic            p_w    [DEPTH];
   logic [DW-1:0]   d_w    [DEPTH];

   assign req_value = req_tdata[DW-1:0];
   assign req_key   = req_tdata[2*DW-1:DW];
   assign req_func  = func_type'(req_tuser);
   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // row of slot cells, slot 0 is the front
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic          p_taps [LOG];
      logic [DW-1:0] d_taps [LOG];
      logic [DW-1:0] prev_elem, next_elem;
      logic          prev_p, prev2_p;

      for (genvar k = 0; k < LOG; k++) begin : g_tap
         if (i >= (1 << k)) begin : g_lo
            assign p_taps[k] = p_w[i - (1 << k)];
         end else begin : g_lo0
            assign p_taps[k] = 1'b0;
         end
         if (i + (1 << k) < DEPTH) begin : g_hi
            assign d_taps[k] = d_w[i + (1 << k)];
         end else begin : g_hi0
            assign d_taps[k] = '0;
         end
      end

      if (i > 0) begin : g_prev
         assign prev_elem = elem_w[i-1];
         assign prev_p    = p_w[i-1];
      end else begin : g_prev0
         assign prev_elem = '0;
         assign prev_p    = 1'b0;
      end
      if (i > 1) begin : g_prev2
         assign prev2_p = p_w[i-2];
      end else begin : g_prev20
         assign prev2_p = 1'b0;
      end
      if (i < DEPTH - 1) begin : g_next
         assign next_elem = elem_w[i+1];
      end else begin : g_next0
         assign next_elem = elem_w[i];
      end

      dqk_cell #(
         .DW    (DW),
         .CW    (CW),
         .LOG   (LOG),
         .SW    (SW),
         .INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (count_ff),
         .step      (step_ff),
         .value     (cell_value),
         .key       (req_key),
         .prev_elem (prev_elem),
         .next_elem (next_elem),
         .prev_p    (prev_p),
         .prev2_p   (prev2_p),
         .p_taps    (p_taps),
         .d_taps    (d_taps),
         .elem_out  (elem_w[i]),
         .p_out     (p_w[i]),
         .d_out     (d_w[i])
      );
   end

   // outcome of the held operation, judged from the fill count and, after the scan, from the cells
   always_comb begin
      res_data   = '0;
      res_found  = 1'b0;
      res_status = SC_OK;
      res_count  = count_ff;
      res_commit = 1'b0;
      case (func_ff)
         FN_PUSH_BACK, FN_PUSH_FRONT: begin
            if (count_ff == CW'(DEPTH)) begin
               res_status = SC_FULL;
            end else begin
               res_commit = 1'b1;
               res_count  = count_ff + CW'(1);
            end
         end
         FN_POP_FRONT, FN_POP_BACK: begin
            if (count_ff == '0) begin
               res_status = SC_EMPTY;
            end else begin
               res_commit = 1'b1;
               res_count  = count_ff - CW'(1);
               res_data   = (func_ff == FN_POP_FRONT) ? elem_w[0] : d_w[0];
            end
         end
         FN_SEARCH: begin
            res_found = p_w[DEPTH-1];
         end
         FN_INSERT_AFTER, FN_INSERT_BEFORE: begin
            if (count_ff == CW'(DEPTH)) begin
               res_status = SC_FULL;
            end else if (!p_w[DEPTH-1]) begin
               res_status = SC_NOKEY;
            end else begin
               res_commit = 1'b1;
               res_count  = count_ff + CW'(1);
            end
         end
         FN_CLEAR: begin
            res_count = '0;
         end
         default: begin
            res_count = count_ff;
         end
      endcase
   end

   always_comb begin
      needs_scan = (req_func == FN_POP_BACK) || (req_func == FN_SEARCH) ||
                   (req_func == FN_INSERT_AFTER) || (req_func == FN_INSERT_BEFORE);
   end

   // sequencer: accept, optional doubling scan, then apply and emit
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      ctl.init     = 1'b0;
      ctl.scan     = 1'b0;
      ctl.apply    = 1'b0;
      ctl.func     = func_ff;
      cell_value   = value_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctl.func   = req_func;
            cell_value = req_value;
            if (accept) begin
               ctl.init = 1'b1;
               func_in  = req_func;
               value_in = req_value;
               step_in  = '0;
               state_in = needs_scan ? ST_SCAN : ST_APPLY;
            end
         end
         ST_SCAN: begin
            ctl.scan = 1'b1;
            if (step_ff == SW'(LOG - 1)) begin
               step_in  = '0;
               state_in = ST_APPLY;
            end else begin
               step_in = step_ff + SW'(1);
            end
         end
         ST_APPLY: begin
            // hold here while the output register is still occupied
            if (slot_free) begin
               ctl.apply    = res_commit;
               count_in     = res_count;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RS_W'({res_count, res_status, res_found, res_data});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `DQK_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(DEPTH), "fill count beyond depth")
   `DQK_ASSERT_ALWAYS(a_step_bound, (state_ff != ST_SCAN) || (step_ff <= SW'(LOG - 1)), "scan step out of range")
   `DQK_ASSERT_NEXT(a_rsp_from_apply, !rsp_valid_ff || rsp_tready, !rsp_valid_ff || ($past(state_ff) == ST_APPLY), "result loaded outside apply")
   `DQK_ASSERT_NEXT(a_clear_empties, (state_ff == ST_APPLY) && slot_free && (func_ff == FN_CLEAR), count_ff == '0, "clear left elements")
   `DQK_ASSERT_NEXT(a_count_stable, state_ff != ST_APPLY, $stable(count_ff), "fill count moved outside apply")

endmodule

>>> sv/dqk_cell.sv
// One deque slot: element register, match prefix flag and pop-back data carrier.
module dqk_cell
   import dqk_pkg::*;
#(
   parameter int DW    = DATA_WIDTH_DEF,
   parameter int CW    = 5,
   parameter int LOG   = 4,
   parameter int SW    = 2,
   parameter int INDEX = 0
) (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  logic [CW-1:0] count,
   input  logic [SW-1:0] step,
   input  logic [DW-1:0] value,
   input  logic [DW-1:0] key,
   input  logic [DW-1:0] prev_elem,
   input  logic [DW-1:0] next_elem,
   input  logic          prev_p,
   input  logic          prev2_p,
   input  logic          p_taps [LOG],
   input  logic [DW-1:0] d_taps [LOG],
   output logic [DW-1:0] elem_out,
   output logic          p_out,
   output logic [DW-1:0] d_out
);

   logic [DW-1:0] elem_ff, elem_in;
   logic          p_ff, p_in;
   logic [DW-1:0] d_ff, d_in;
   logic          occupied, is_last, is_end;
   logic [DW-1:0] cmp;

   always_comb begin
      occupied = CW'(INDEX) < count;
      is_last  = CW'(INDEX + 1) == count;
      is_end   = CW'(INDEX) == count;
      cmp      = (ctl.func == FN_SEARCH) ? value : key;
      elem_in  = elem_ff;
      p_in     = p_ff;
      d_in     = d_ff;
      if (ctl.init) begin
         p_in = occupied && (elem_ff == cmp);
         d_in = is_last ? elem_ff : '0;
      end else if (ctl.scan) begin
         // widen the prefix toward the back, gather the carrier toward the front
         p_in = p_ff | p_taps[step];
         d_in = d_ff | d_taps[step];
      end
      if (ctl.apply) begin
         case (ctl.func)
            FN_PUSH_BACK: begin
               if (is_end) elem_in = value;
            end
            FN_PUSH_FRONT: begin
               elem_in = (INDEX == 0) ? value : prev_elem;
            end
            FN_POP_FRONT: begin
               elem_in = next_elem;
            end
            FN_INSERT_AFTER: begin
               if (prev_p && !prev2_p) elem_in = value;
               else if (prev_p)        elem_in = prev_elem;
            end
            FN_INSERT_BEFORE: begin
               if (p_ff && !prev_p) elem_in = value;
               else if (p_ff)       elem_in = prev_elem;
            end
            default: begin
               elem_in = elem_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      p_ff    <= p_in;
      d_ff    <= d_in;
   end

   assign elem_out = elem_ff;
   assign p_out    = p_ff;
   assign d_out    = d_ff;

endmodule

>>> bench/bounded_deque_with_key_insert_core_tb.sv
// Self-checking testbench for the bounded deque with keyed insert.
`timescale 1ns / 100ps

module bounded_deque_with_key_insert_core_tb;
   import dqk_pkg::*;

   localparam int DEPTH       = DEPTH_DEF;
   localparam int DW          = DATA_WIDTH_DEF;
   localparam int CW          = $clog2(DEPTH + 1);
   localparam int RQ_W        = ((2 * DW + 7) / 8) * 8;
   localparam int RS_W        = ((DW + 3 + CW + 7) / 8) * 8;
   localparam int RANDOM_OPS  = 1950;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_AT     = 300;   // requests accepted before the long response hold
   localparam int HOLD_LEN    = 400;   // cycles of that hold

   // One request as the sender queues it, with the idle cycles that follow it.
   typedef struct {
      func_type      op;
      logic [DW-1:0] value;
      logic [DW-1:0] key;
      int            gap;
   } deque_request_type;

   // One response as the deque should report it.
   typedef struct {
      logic [DW-1:0] data;
      logic          found;
      status_type    status;
      logic [CW-1:0] fill;
   } deque_outcome_type;

   logic            clock      = 1'b0;
   logic            reset      = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [RQ_W-1:0] req_tdata  = '0;   // value, key
   logic [FUNC_W-1:0] req_tuser = '0;  // func
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [RS_W-1:0] rsp_tdata;         // data, found, status, fill_count

   deque_request_type pending_q[$];    // requests not yet offered
   deque_outcome_type outcome_q[$];    // responses owed by the deque, oldest first
   deque_request_type cur_req;
   deque_outcome_type want;
   int              gap_left     = 0;
   int              accepted_cnt = 0;
   int              errors       = 0;
   int              cycle_cnt    = 0;
   int              hold_left    = 0;
   bit              hold_done    = 1'b0;
   int              stall_left   = 0;
   int              stall_pct    = 0;

   // Predictor state: slot 0 is the front, only slots below the fill count hold data.
   logic [DW-1:0]   slot_model [DEPTH];
   int              fill_model = 0;

   bounded_deque_with_key_insert_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Apply one operation to the predictor deque and return the response it owes.
   function automatic deque_outcome_type apply_deque_op(func_type op, logic [DW-1:0] value,
                                                        logic [DW-1:0] key);
      deque_outcome_type o;
      int pos;
      int i;
      o.data   = '0;
      o.found  = 1'b0;
      o.status = SC_OK;
      case (op)
         FN_PUSH_BACK, FN_PUSH_FRONT: begin
            if (fill_model >= DEPTH) begin
               o.status = SC_FULL;
            end else begin
               pos = (op == FN_PUSH_BACK) ? fill_model : 0;
               for (i = fill_model; i > pos; i--) slot_model[i] = slot_model[i-1];
               slot_model[pos] = value;
               fill_model++;
            end
         end
         FN_POP_FRONT, FN_POP_BACK: begin
            if (fill_model == 0) begin
               o.status = SC_EMPTY;
            end else begin
               pos = (op == FN_POP_FRONT) ? 0 : fill_model - 1;
               o.data = slot_model[pos];
               for (i = pos; i + 1 < fill_model; i++) slot_model[i] = slot_model[i+1];
               fill_model--;
            end
         end
         FN_SEARCH: begin
            for (i = 0; i < fill_model; i++)
               if (slot_model[i] == value) o.found = 1'b1;
         end
         FN_INSERT_AFTER, FN_INSERT_BEFORE: begin
            // Fullness wins over a missing key.
            if (fill_model >= DEPTH) begin
               o.status = SC_FULL;
            end else begin
               pos = fill_model;
               for (i = fill_model - 1; i >= 0; i--)
                  if (slot_model[i] == key) pos = i;   // frontmost match survives
               if (pos == fill_model) begin
                  o.status = SC_NOKEY;
               end else begin
                  if (op == FN_INSERT_AFTER) pos++;
                  for (i = fill_model; i > pos; i--) slot_model[i] = slot_model[i-1];
                  slot_model[pos] = value;
                  fill_model++;
               end
            end
         end
         default: begin
            fill_model = 0;
         end
      endcase
      o.fill = fill_model[CW-1:0];
      return o;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Values come mostly from a small set so searches and insert keys hit often.
   function automatic logic [DW-1:0] pick_word();
      if ($urandom_range(0, 99) >= 70) return $urandom();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'h0000_0002;
         3: return 32'h0000_0003;
         4: return 32'hffff_ffff;
         5: return 32'h8000_0000;
         6: return 32'h7fff_ffff;
         default: return 32'h0000_0055;
      endcase
   endfunction

   // add_pct steers the fill level: high values grow the deque, low values drain it.
   function automatic func_type pick_op(int add_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return FN_CLEAR;
      if (r < 12) return FN_SEARCH;
      if ($urandom_range(0, 99) < add_pct) begin
         case ($urandom_range(0, 3))
            0: return FN_PUSH_BACK;
            1: return FN_PUSH_FRONT;
            2: return FN_INSERT_AFTER;
            default: return FN_INSERT_BEFORE;
         endcase
      end
      return $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
   endfunction

   task automatic queue_op(func_type op, logic [DW-1:0] value, logic [DW-1:0] key, int gap);
      deque_request_type r;
      r.op    = op;
      r.value = value;
      r.key   = key;
      r.gap   = gap;
      pending_q.push_back(r);
   endtask

   // Hold until every queued request is taken and every response has come back.
   task automatic wait_drained();
      while (pending_q.size() != 0 || req_tvalid || outcome_q.size() != 0) @(negedge clock);
   endtask

   // Request driver: predict on each accepted request, then offer the next one
   // after its idle gap. Valid stays up while the deque holds off.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
         fill_model = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(apply_deque_op(cur_req.op, cur_req.value, cur_req.key));
            accepted_cnt <= accepted_cnt + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               cur_req = pending_q.pop_front();
               req_tdata  <= RQ_W'({cur_req.key, cur_req.value});
               req_tuser  <= cur_req.op;
               req_tvalid <= 1'b1;
               gap_left = cur_req.gap;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response sink: random short and long stalls, overridden by the long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < stall_pct) stall_left <= gap_len();
      end
   end

   // Long hold, once: the sender keeps offering so the deque backs up and
   // stalls its request side. Also re-pick the stall rate now and then so
   // some stretches run with no stalls at all.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end
      if (cycle_cnt % 256 == 0) begin
         case ($urandom_range(0, 2))
            0: stall_pct <= 0;
            1: stall_pct <= 10;
            default: stall_pct <= 30;
         endcase
      end
   end

   // Response checker: compare every accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            $error("response with none pending: tdata %h", rsp_tdata);
            errors++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_tdata[DW-1:0] !== want.data) begin
               $error("data: expected %h, got %h", want.data, rsp_tdata[DW-1:0]);
               errors++;
            end
            if (rsp_tdata[DW] !== want.found) begin
               $error("found: expected %b, got %b", want.found, rsp_tdata[DW]);
               errors++;
            end
            if (rsp_tdata[DW+2:DW+1] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[DW+2:DW+1]);
               errors++;
            end
            if (rsp_tdata[DW+3+CW-1:DW+3] !== want.fill) begin
               $error("fill_count: expected %0d, got %0d", want.fill,
                      rsp_tdata[DW+3+CW-1:DW+3]);
               errors++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("bounded_deque_with_key_insert_core_tb NOT OK");
         $finish;
      end
   end

   initial begin
      int issued;
      int len;
      int add_pct;
      bit calm;
      int i;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty deque, extremes of value, duplicate keys, inserts at
      // the head and inside, missing key, fill to full, drops when full, clear.
      queue_op(FN_POP_FRONT,     '0,           '0,           0);   // pop on empty
      queue_op(FN_SEARCH,        '0,           '0,           1);
      queue_op(FN_INSERT_AFTER,  32'h1,        '0,           0);   // key absent, empty
      queue_op(FN_PUSH_BACK,     32'h7fffffff, '0,           0);
      queue_op(FN_PUSH_FRONT,    32'h80000000, '0,           2);
      queue_op(FN_PUSH_BACK,     32'h5,        '0,           0);
      queue_op(FN_PUSH_BACK,     32'h5,        '0,           0);   // duplicate key
      queue_op(FN_INSERT_BEFORE, 32'hffffffff, 32'h5,        0);
      queue_op(FN_INSERT_AFTER,  32'h0,        32'h5,        3);
      queue_op(FN_INSERT_AFTER,  32'h9,        32'h12345678, 0);   // key absent
      queue_op(FN_SEARCH,        32'h80000000, '0,           0);
      queue_op(FN_INSERT_BEFORE, 32'h3,        32'h80000000, 0);   // new head
      queue_op(FN_INSERT_AFTER,  32'h4,        32'h7fffffff, 0);   // after the third element
      for (i = 0; i < 8; i++)
         queue_op(i[0] ? FN_PUSH_FRONT : FN_PUSH_BACK, $urandom(), '0, 0);
      queue_op(FN_PUSH_BACK,     32'h6,        '0,           0);   // full: dropped
      queue_op(FN_INSERT_AFTER,  32'h7,        32'h12345678, 0);   // full beats missing key
      queue_op(FN_POP_BACK,      '0,           '0,           0);
      queue_op(FN_POP_FRONT,     '0,           '0,           1);
      queue_op(FN_CLEAR,         '0,           '0,           0);
      queue_op(FN_POP_BACK,      '0,           '0,           0);   // empty after clear

      // Sender pause: let every response come home before the random part.
      wait_drained();

      // Random bursts, each steering the fill level up, down or level, some
      // with back-to-back requests and some with idle gaps.
      issued = 0;
      while (issued < RANDOM_OPS) begin
         len  = $urandom_range(10, 40);
         calm = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 2))
            0: add_pct = 75;
            1: add_pct = 25;
            default: add_pct = 50;
         endcase
         for (i = 0; i < len; i++)
            queue_op(pick_op(add_pct), pick_word(), pick_word(), calm ? 0 : gap_len());
         issued += len;
         while (pending_q.size() > 16) @(negedge clock);
         if ($urandom_range(0, 19) == 0) wait_drained();
      end

      wait_drained();
      repeat (16) @(negedge clock);
      if (errors == 0) begin
         $display("bounded_deque_with_key_insert_core_tb OK");
      end else begin
         $display("bounded_deque_with_key_insert_core_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/dqk_pkg.sv
sv/dqk_cell.sv
sv/bounded_deque_with_key_insert_core.sv
bench/bounded_deque_with_key_insert_core_tb.sv
